// ===== rtl/i2crm_pkg.sv =====
package i2crm_pkg;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_START1,
		PH_ADDR1,
		PH_REG,
		PH_VALUE,
		PH_START2,
		PH_ADDR2,
		PH_READ,
		PH_RACK,
		PH_STOP
	} phase_t;

	localparam logic [1:0] ERR_OK        = 2'd0;
	localparam logic [1:0] ERR_BUS_BUSY  = 2'd1;
	localparam logic [1:0] ERR_ADDR_NACK = 2'd2;
	localparam logic [1:0] ERR_DATA_NACK = 2'd3;

	localparam int unsigned QueueDepth = 2;

	typedef struct packed {
		logic       sda_in;
		logic       command_valid;
		logic       func;
		logic [6:0] device_address;
		logic [7:0] register_index;
		logic [7:0] write_value;
		logic [7:0] read_length;
	} tick_t;

	typedef struct packed {
		logic       scl_release;
		logic       sda_release;
		logic       busy_res;
		logic [7:0] read_byte;
		logic       read_valid;
		logic       read_last;
		logic       done_res;
		logic [1:0] error_code;
	} result_t;

endpackage

// ===== rtl/i2crm_tick_if.sv =====
interface i2crm_tick_if import i2crm_pkg::*; ();
	logic  valid;
	logic  ready;
	tick_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/i2crm_result_if.sv =====
interface i2crm_result_if import i2crm_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/i2crm_fifo.sv =====
module i2crm_fifo import i2crm_pkg::*; #(
	parameter int unsigned Depth = QueueDepth,
	parameter int unsigned Width = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [Width-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [Width-1:0] out_data
);
	localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CW = $clog2(Depth + 1);

	logic [Width-1:0] mem_q [Depth];
	logic [AW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;
	logic             push, pop;

	assign in_ready  = cnt_q != CW'(Depth);
	assign out_valid = cnt_q != '0;
	assign out_data  = mem_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end
endmodule

// ===== rtl/i2crm_engine.sv =====
module i2crm_engine import i2crm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    tick_valid,
	output logic    tick_ready,
	input  tick_t   tick,
	output logic    res_valid,
	input  logic    res_ready,
	output result_t res
);
	phase_t     phase_q, ph, phase_d;
	logic [1:0] quarter_q, qt, quarter_d;
	logic [3:0] bit_count_q, bit_count_d;
	logic [7:0] shift_q, shift_d, bytes_left_q, bytes_left_d;
	logic [6:0] addr_q, addr_d;
	logic [7:0] reg_q, reg_d, val_q, val_d;
	logic       is_read_q, is_read_d;
	logic [1:0] last_err_q, last_err_d;
	logic       scl_q, scl_d, sda_q, sda_d;
	logic       out_valid_q;
	result_t    out_q, r;
	logic       step, fail, last_byte;
	logic [3:0] bc_inc;
	logic [7:0] shift_in;

	assign tick_ready = !out_valid_q || res_ready;
	assign step       = tick_valid && tick_ready;
	assign res_valid  = out_valid_q;
	assign res        = out_q;
	assign last_byte  = bytes_left_q <= 8'd1;
	assign bc_inc     = bit_count_q + 4'd1;
	assign shift_in   = {shift_q[6:0], tick.sda_in};

	always_comb begin
		ph = phase_q;
		qt = quarter_q;
		phase_d = phase_q;
		quarter_d = quarter_q;
		bit_count_d = bit_count_q;
		shift_d = shift_q;
		bytes_left_d = bytes_left_q;
		addr_d = addr_q;
		reg_d = reg_q;
		val_d = val_q;
		is_read_d = is_read_q;
		last_err_d = last_err_q;
		scl_d = scl_q;
		sda_d = sda_q;
		fail = 1'b0;
		r = '0;
		r.busy_res = 1'b1;
		if (phase_q == PH_IDLE && tick.command_valid) begin
			is_read_d = tick.func;
			addr_d = tick.device_address;
			reg_d = tick.register_index;
			val_d = tick.write_value;
			bytes_left_d = (tick.read_length == 8'd0) ? 8'd1 : tick.read_length;
			last_err_d = ERR_OK;
			ph = PH_START1;
			qt = 2'd0;
			phase_d = PH_START1;
			quarter_d = 2'd0;
		end
		unique case (ph)
			PH_START1, PH_START2: begin
				if (qt == 2'd0) begin
					sda_d = 1'b1;
					scl_d = 1'b1;
					fail = !tick.sda_in;
					quarter_d = 2'd1;
				end else if (qt == 2'd1) begin
					sda_d = 1'b0;
					fail = tick.sda_in;
					quarter_d = 2'd2;
				end else begin
					scl_d = 1'b0;
					phase_d = (ph == PH_START1) ? PH_ADDR1 : PH_ADDR2;
					shift_d = {addr_q, (ph == PH_START2)};
					bit_count_d = '0;
					quarter_d = 2'd0;
				end
			end
			PH_ADDR1, PH_REG, PH_VALUE, PH_ADDR2: begin
				if (qt == 2'd0) begin
					scl_d = 1'b0;
					quarter_d = 2'd1;
				end else if (qt == 2'd1) begin
					sda_d = bit_count_q[3] ? 1'b1 : shift_q[7];
					if (!bit_count_q[3]) begin
						shift_d = {shift_q[6:0], 1'b0};
					end
					quarter_d = 2'd2;
				end else begin
					scl_d = 1'b1;
					quarter_d = 2'd0;
					if (!bit_count_q[3]) begin
						bit_count_d = bc_inc;
					end else begin
						bit_count_d = '0;
						if (tick.sda_in) begin
							last_err_d = (ph == PH_ADDR1 || ph == PH_ADDR2) ?
								ERR_ADDR_NACK : ERR_DATA_NACK;
							phase_d = PH_STOP;
						end else if (ph == PH_ADDR1) begin
							phase_d = PH_REG;
							shift_d = reg_q;
						end else if (ph == PH_REG) begin
							phase_d = is_read_q ? PH_START2 : PH_VALUE;
							shift_d = val_q;
						end else if (ph == PH_VALUE) begin
							phase_d = PH_STOP;
						end else begin
							phase_d = PH_READ;
							shift_d = '0;
						end
					end
				end
			end
			PH_READ: begin
				if (qt == 2'd0) begin
					scl_d = 1'b0;
					if (bit_count_q == '0) begin
						sda_d = 1'b1;
					end
					quarter_d = 2'd1;
				end else begin
					scl_d = 1'b1;
					shift_d = shift_in;
					bit_count_d = bc_inc;
					quarter_d = 2'd0;
					if (bc_inc[3]) begin
						r.read_byte = shift_in;
						r.read_valid = 1'b1;
						r.read_last = last_byte;
						phase_d = PH_RACK;
					end
				end
			end
			PH_RACK: begin
				unique case (qt)
					2'd0: begin
						scl_d = 1'b0;
						quarter_d = 2'd1;
					end
					2'd1: begin
						sda_d = last_byte;
						quarter_d = 2'd2;
					end
					2'd2: begin
						scl_d = 1'b1;
						quarter_d = 2'd3;
					end
					default: begin
						scl_d = 1'b0;
						quarter_d = 2'd0;
						if (last_byte) begin
							phase_d = PH_STOP;
						end else begin
							bytes_left_d = bytes_left_q - 8'd1;
							phase_d = PH_READ;
							shift_d = '0;
							bit_count_d = '0;
						end
					end
				endcase
			end
			PH_STOP: begin
				unique case (qt)
					2'd0: begin
						scl_d = 1'b0;
						quarter_d = 2'd1;
					end
					2'd1: begin
						sda_d = 1'b0;
						quarter_d = 2'd2;
					end
					2'd2: begin
						scl_d = 1'b1;
						quarter_d = 2'd3;
					end
					default: begin
						sda_d = 1'b1;
						r.done_res = 1'b1;
						r.error_code = last_err_q;
						phase_d = PH_IDLE;
						quarter_d = 2'd0;
					end
				endcase
			end
			default: begin
				phase_d = PH_IDLE;
				quarter_d = 2'd0;
				scl_d = 1'b1;
				sda_d = 1'b1;
				r.busy_res = 1'b0;
			end
		endcase
		r.scl_release = scl_d;
		r.sda_release = sda_d;
		if (fail) begin
			r.done_res = 1'b1;
			r.error_code = ERR_BUS_BUSY;
			last_err_d = ERR_BUS_BUSY;
			phase_d = PH_IDLE;
			quarter_d = 2'd0;
			scl_d = 1'b1;
			sda_d = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_q <= r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			quarter_q <= '0;
			bit_count_q <= '0;
			shift_q <= '0;
			bytes_left_q <= '0;
			addr_q <= '0;
			reg_q <= '0;
			val_q <= '0;
			is_read_q <= 1'b0;
			last_err_q <= ERR_OK;
			scl_q <= 1'b1;
			sda_q <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				phase_q <= phase_d;
				quarter_q <= quarter_d;
				bit_count_q <= bit_count_d;
				shift_q <= shift_d;
				bytes_left_q <= bytes_left_d;
				addr_q <= addr_d;
				reg_q <= reg_d;
				val_q <= val_d;
				is_read_q <= is_read_d;
				last_err_q <= last_err_d;
				scl_q <= scl_d;
				sda_q <= sda_d;
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

// ===== rtl/i2c_register_master_top.sv =====
// I2C register master, open-drain, one bus tick per item.
// Channel tick (sink): one item per prescaler tick carrying the sampled SDA
// level and an optional command (write or read of 1..255 bytes).
// Channel result (source): exactly one item per tick item, giving the SCL and
// SDA release levels for that tick, busy, received bytes and completion status.
// A front queue of Depth entries (two by default) holds incoming ticks; the bus
// engine takes one per cycle unless its result is still waiting to be taken,
// and registers its result: a result is valid the cycle after the engine accepts
// its tick, and each tick passes through a queue entry and the output register.
// A result is held in the output register while the receiver stalls; the
// queue then fills and tick ready drops until the result is taken.
// Reset leaves the bus idle with both lines released and no item pending.
module i2c_register_master_top import i2crm_pkg::*; #(
	parameter int unsigned Depth = QueueDepth
) (
	input  logic   clk,
	input  logic   arst_n,
	i2crm_tick_if.sink     tick,
	i2crm_result_if.source result
);
	localparam int unsigned TW = $bits(tick_t);

	logic          q_valid, q_ready;
	logic [TW-1:0] q_data;

	i2crm_fifo #(.Depth(Depth), .Width(TW)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (tick.valid),
		.in_ready  (tick.ready),
		.in_data   (tick.data),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_data  (q_data)
	);

	i2crm_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (q_valid),
		.tick_ready (q_ready),
		.tick       (tick_t'(q_data)),
		.res_valid  (result.valid),
		.res_ready  (result.ready),
		.res        (result.data)
	);
endmodule
